FILE: rtl/core/cws_pkg.sv
// Shared types and constants for the coil winding sequencer.
// No dependencies; used by the top level and its port checker.
package cws_pkg;

  // Hall sensor averaging window, in samples
  localparam int WINDOW_SAMPLES = 20;

  localparam int SAMPLE_W = 10;
  localparam int SUM_W    = 15;
  localparam int COUNT_W  = 16;
  localparam int PWM_W    = 8;
  localparam int WIN_W    = $clog2(WINDOW_SAMPLES + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 32;

  // Exact floor divide by WINDOW_SAMPLES for any SUM_W-bit value:
  // multiply by a rounded-up reciprocal, then shift.
  localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW_SAMPLES);
  localparam int MULT_W    = SUM_W + 2;
  localparam int PROD_W    = SUM_W + MULT_W;
  localparam logic [MULT_W-1:0] DIV_MULT =
    MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES));

  localparam logic [PWM_W-1:0]   RAMP_STEP = 8'd10;
  localparam logic [PWM_W-1:0]   RAMP_CEIL = 8'd229;
  localparam logic [COUNT_W-1:0] TURNS_BEFORE_TRAVERSE = 16'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [WIN_W-1:0]   WINDOW_RELOAD = WIN_W'(WINDOW_SAMPLES);

  // Register reset values
  localparam logic [COUNT_W-1:0]  TARGET_TURNS_RST   = 16'd0;
  localparam logic [COUNT_W-1:0]  TRAVERSE_LIMIT_RST = 16'd46080;
  localparam logic [SAMPLE_W-1:0] LOW_THRESHOLD_RST  = 10'd400;
  localparam logic [SAMPLE_W-1:0] HIGH_THRESHOLD_RST = 10'd700;
  localparam logic [PWM_W-1:0]    PWM_INITIAL_RST    = 8'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_TURNS   = 3'd0,
    CFG_TRAVERSE_LIMIT = 3'd1,
    CFG_LOW_THRESHOLD  = 3'd2,
    CFG_HIGH_THRESHOLD = 3'd3,
    CFG_PWM_INITIAL    = 3'd4
  } cfg_index_t;

  // Input item, last field in the lowest bit
  typedef struct packed {
    logic [1:0]          pad;
    logic [SAMPLE_W-1:0] sensor_sample;
    logic                ramp_tick;
    logic                abort_request;
    logic                stop_request;
    logic                start_request;
  } in_item_t;

  // Result item, last field in the lowest bit
  typedef struct packed {
    logic [3:0]         pad;
    logic               finished;
    logic [COUNT_W-1:0] turns_done;
    logic               running;
    logic [PWM_W-1:0]   pwm_duty;
    logic               direction;
    logic               step_level;
  } out_item_t;

endpackage

FILE: rtl/core/coil_winding_sequencer.sv
// Coil winding sequencer top level: run control, sensor filter, turn counter,
// traverse stepper and output skid stage. Depends on cws_pkg.

// One input item is one control tick and gives exactly one result item.
// Every item is handled in one pass: the next-state logic (one small
// constant-reciprocal multiply for the window average, a few compares and
// increments) sits between the state registers and the result register, so
// an item can be accepted on every clock. Results leave through an output
// register backed by a one-entry skid register; s_tready stays high until
// both are full, so a stalled consumer costs nothing until two results wait.
// A start request arms a run; the spindle PWM ramps by 10 per ramp tick up to
// 239; after more than two turns the traverse step output toggles each tick
// and reverses direction at traverse_limit. The hall sensor is averaged over
// 20 samples with hysteresis and each falling level counts a turn; reaching
// target_turns ends the run and pulses finished. Configuration writes are
// always taken (cfg_ready is tied high) and must only occur while idle.
module coil_winding_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  // input item: start_request, stop_request, abort_request, ramp_tick,
  // sensor_sample[9:0], zero pad
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cws_pkg::IN_TDATA_W-1:0] s_tdata,
  // result item: step_level, direction, pwm_duty[7:0], running,
  // turns_done[15:0], finished, zero pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cws_pkg::OUT_TDATA_W-1:0] m_tdata,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cws_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cws_pkg::*;

  // Configuration registers
  logic [COUNT_W-1:0]  target_turns;
  logic [COUNT_W-1:0]  traverse_limit;
  logic [SAMPLE_W-1:0] low_threshold;
  logic [SAMPLE_W-1:0] high_threshold;
  logic [PWM_W-1:0]    pwm_initial;

  // Sequencer state
  logic               run_flag,       run_flag_next;
  logic               turn_latch,     turn_latch_next;
  logic               sensor_level,   sensor_level_next;
  logic [SUM_W-1:0]   sample_sum,     sample_sum_next;
  logic [WIN_W-1:0]   window_left,    window_left_next;
  logic [COUNT_W-1:0] step_count,     step_count_next;
  logic               traverse_right, traverse_right_next;
  logic [COUNT_W-1:0] turn_count,     turn_count_next;
  logic [PWM_W-1:0]   pwm_level,      pwm_level_next;
  logic               step_toggle,    step_toggle_next;

  // Output register and skid register
  out_item_t out_item, skid_item, item_next;
  logic      out_valid, skid_valid;

  in_item_t         in_item;
  logic             accept;
  logic             armed;
  logic             finish;
  logic [PROD_W-1:0] avg_prod;
  logic [SUM_W-1:0] avg;

  assign in_item   = in_item_t'(s_tdata);
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = !skid_valid;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_TDATA_W'(out_item);

  // Window average: floor(sample_sum / WINDOW_SAMPLES) by reciprocal multiply
  assign avg_prod = PROD_W'(sample_sum) * PROD_W'(DIV_MULT);
  assign avg      = SUM_W'(avg_prod >> DIV_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_turns   <= TARGET_TURNS_RST;
      traverse_limit <= TRAVERSE_LIMIT_RST;
      low_threshold  <= LOW_THRESHOLD_RST;
      high_threshold <= HIGH_THRESHOLD_RST;
      pwm_initial    <= PWM_INITIAL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TARGET_TURNS:   target_turns   <= cfg_data;
        CFG_TRAVERSE_LIMIT: traverse_limit <= cfg_data;
        CFG_LOW_THRESHOLD:  low_threshold  <= cfg_data[SAMPLE_W-1:0];
        CFG_HIGH_THRESHOLD: high_threshold <= cfg_data[SAMPLE_W-1:0];
        CFG_PWM_INITIAL:    pwm_initial    <= cfg_data[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state for one tick
  always_comb begin
    run_flag_next       = run_flag;
    turn_latch_next     = turn_latch;
    sensor_level_next   = sensor_level;
    sample_sum_next     = sample_sum;
    window_left_next    = window_left;
    step_count_next     = step_count;
    traverse_right_next = traverse_right;
    turn_count_next     = turn_count;
    pwm_level_next      = pwm_level;
    step_toggle_next    = step_toggle;
    finish              = 1'b0;

    armed = run_flag || in_item.start_request;

    if (armed && (step_count < traverse_limit)) begin
      if (turn_count >= target_turns) begin
        // run complete: clear and restore
        finish              = 1'b1;
        turn_latch_next     = 1'b0;
        step_count_next     = '0;
        traverse_right_next = 1'b1;
        turn_count_next     = '0;
        pwm_level_next      = pwm_initial;
      end else begin
        if (in_item.ramp_tick && (pwm_level <= RAMP_CEIL)) begin
          pwm_level_next = pwm_level + RAMP_STEP;
        end
        if (turn_count > TURNS_BEFORE_TRAVERSE) begin
          step_toggle_next = !step_toggle;
          step_count_next  = step_count + 1'b1;
        end
      end
    end else if (armed) begin
      // traverse end reached: reverse
      step_count_next     = '0;
      traverse_right_next = !traverse_right;
    end

    run_flag_next = armed && !finish;

    // Sensor filter and turn counter, only while the run stays armed
    if (run_flag_next) begin
      if (window_left > WIN_W'(1)) begin
        sample_sum_next  = sample_sum + SUM_W'(in_item.sensor_sample);
        window_left_next = window_left - 1'b1;
      end else begin
        sample_sum_next  = avg;
        window_left_next = WINDOW_RELOAD;
        if ((avg < SUM_W'(low_threshold)) && sensor_level) begin
          sensor_level_next = 1'b0;
        end
        if ((avg > SUM_W'(high_threshold)) && !sensor_level_next) begin
          sensor_level_next = 1'b1;
        end
      end
      if (!sensor_level_next && !turn_latch) begin
        if (turn_count != COUNT_MAX) begin
          turn_count_next = turn_count + 1'b1;
        end
        turn_latch_next = 1'b1;
      end else if (sensor_level_next && turn_latch) begin
        turn_latch_next = 1'b0;
      end
    end

    if (in_item.stop_request) begin
      run_flag_next = 1'b0;
    end
    if (in_item.abort_request) begin
      run_flag_next       = 1'b0;
      traverse_right_next = 1'b1;
    end

    item_next            = '0;
    item_next.step_level = step_toggle_next;
    item_next.direction  = traverse_right_next;
    item_next.pwm_duty   = run_flag_next ? pwm_level_next : '0;
    item_next.running    = run_flag_next;
    item_next.turns_done = turn_count_next;
    item_next.finished   = finish;
  end

  // State registers advance only on an accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag       <= 1'b0;
      turn_latch     <= 1'b0;
      sensor_level   <= 1'b1;
      sample_sum     <= '0;
      window_left    <= WINDOW_RELOAD;
      step_count     <= '0;
      traverse_right <= 1'b1;
      turn_count     <= '0;
      pwm_level      <= PWM_INITIAL_RST;
      step_toggle    <= 1'b0;
    end else if (accept) begin
      run_flag       <= run_flag_next;
      turn_latch     <= turn_latch_next;
      sensor_level   <= sensor_level_next;
      sample_sum     <= sample_sum_next;
      window_left    <= window_left_next;
      step_count     <= step_count_next;
      traverse_right <= traverse_right_next;
      turn_count     <= turn_count_next;
      pwm_level      <= pwm_level_next;
      step_toggle    <= step_toggle_next;
    end
  end

  // Output register with skid: park the new result when the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid && m_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        if (out_valid && !m_tready) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid && m_tready) begin
      out_item <= skid_item;
    end else if (accept && !(out_valid && !m_tready)) begin
      out_item <= item_next;
    end
    if (accept && out_valid && !m_tready) begin
      skid_item <= item_next;
    end
  end

endmodule

FILE: rtl/core/cws_checker.sv
// Port-level checks for the coil winding sequencer, bound to the top level.
// Depends on cws_pkg for the result item layout.
module cws_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [cws_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import cws_pkg::*;

  out_item_t res;
  assign res = out_item_t'(m_tdata);

  // A finished run shows stopped, cleared turns and right direction
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.finished) |->
      (!res.running && res.turns_done == '0 && res.direction))
    else $error("finished result without cleared run state");

  // No PWM drive while the run is off
  a_pwm_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.running) |-> (res.pwm_duty == '0))
    else $error("pwm_duty nonzero while not running");

  // The input only waits behind a held result
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind coil_winding_sequencer cws_checker u_cws_checker (.*);
